[src/rti_pkg.sv]
// Package for the ray/triangle intersection block.
// Holds widths, the threshold reset value, mode and status codes, and the t result constants.
// No dependencies.
package rti_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 12;
    localparam int THR_BITS       = 48;
    localparam logic [THR_BITS-1:0] THR_RESET = 48'd6871948;

    localparam logic [2:0] MODE_V0     = 3'd0;
    localparam logic [2:0] MODE_V1     = 3'd1;
    localparam logic [2:0] MODE_V2     = 3'd2;
    localparam logic [2:0] MODE_ORIGIN = 3'd3;
    localparam logic [2:0] MODE_TEST   = 3'd4;

    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_PARALLEL = 3'd1;
    localparam logic [2:0] ST_U_OUT    = 3'd2;
    localparam logic [2:0] ST_V_OUT    = 3'd3;
    localparam logic [2:0] ST_BEHIND   = 3'd4;

    localparam logic [31:0] T_REJECT = 32'hFFFF0000;
    localparam logic [31:0] T_MAX    = 32'h7FFFFFFF;
    localparam logic [31:0] T_MIN    = 32'h80000000;

endpackage

[src/rti_front.sv]
// Front part: accepts input transactions, updates the vertex and origin stores,
// and hands test commands (edges and offset vector) to the queue. Uses rti_pkg.
module rti_front #(
    parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF,
    parameter int VB = COORD_BITS + 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [2:0]                   mode,
    input  logic signed [COORD_BITS-1:0] cx,
    input  logic signed [COORD_BITS-1:0] cy,
    input  logic signed [COORD_BITS-1:0] cz,
    output logic                         cmd_valid,
    input  logic                         cmd_ready,
    output logic [9*VB-1:0]              cmd_data
);

    logic signed [COORD_BITS-1:0] vtx_reg [9];
    logic signed [COORD_BITS-1:0] org_reg [3];
    logic signed [COORD_BITS-1:0] dir [3];
    logic signed [VB-1:0] e1 [3];
    logic signed [VB-1:0] e2 [3];
    logic signed [VB-1:0] tv [3];
    logic acc;

    assign in_ready  = cmd_ready || (mode != rti_pkg::MODE_TEST);
    assign acc       = in_valid && in_ready;
    assign cmd_valid = in_valid && (mode == rti_pkg::MODE_TEST);
    assign dir[0] = cx;
    assign dir[1] = cy;
    assign dir[2] = cz;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            e1[k] = VB'(vtx_reg[3+k]) - VB'(vtx_reg[k]);
            e2[k] = VB'(vtx_reg[6+k]) - VB'(vtx_reg[k]);
            tv[k] = VB'(org_reg[k]) - VB'(vtx_reg[k]);
        end
        cmd_data = {tv[2], tv[1], tv[0], e2[2], e2[1], e2[0], e1[2], e1[1], e1[0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++) vtx_reg[k] <= '0;
            for (int k = 0; k < 3; k++) org_reg[k] <= '0;
        end
        else if (acc)
        begin
            case (mode)
                rti_pkg::MODE_V0:
                begin
                    for (int k = 0; k < 3; k++) vtx_reg[k] <= dir[k];
                end
                rti_pkg::MODE_V1:
                begin
                    for (int k = 0; k < 3; k++) vtx_reg[3+k] <= dir[k];
                end
                rti_pkg::MODE_V2:
                begin
                    for (int k = 0; k < 3; k++) vtx_reg[6+k] <= dir[k];
                end
                rti_pkg::MODE_ORIGIN:
                begin
                    for (int k = 0; k < 3; k++) org_reg[k] <= dir[k];
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

[src/rti_fifo.sv]
// Two-entry queue between front and back parts.
// Generic width; no package dependency.
module rti_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  logic [W-1:0] wr_data,
    output logic         rd_valid,
    input  logic         rd_ready,
    output logic [W-1:0] rd_data
);

    logic [W-1:0] mem_reg [2];
    logic         wp_reg;
    logic         rp_reg;
    logic [1:0]   cnt_reg;
    logic         wr;
    logic         rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

endmodule

[src/rti_back.sv]
// Back part: sequential dot/cross products through one shared multiplier,
// then restoring division for u, v and t. Uses rti_pkg.
module rti_back #(
    parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF,
    parameter int VB = COORD_BITS + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic [12*VB-1:0]              cmd_data,
    input  logic [rti_pkg::THR_BITS-1:0]  det_threshold,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [2:0]                    status,
    output logic                          hit,
    output logic [31:0]                   t_value,
    output logic [16:0]                   u_weight,
    output logic [16:0]                   v_weight
);

    localparam int PB = 2 * VB;          // product of two vector elements
    localparam int CB = PB + 1;          // cross component
    localparam int SB = VB + CB + 3;     // dot product sum
    localparam int NB = SB + 16;         // shifted numerator
    localparam int QW = 34;              // quotient bits kept
    localparam int CW = $clog2(NB + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PX    = 4'd1;
    localparam logic [3:0] S_DET   = 4'd2;
    localparam logic [3:0] S_U     = 4'd3;
    localparam logic [3:0] S_QX    = 4'd4;
    localparam logic [3:0] S_V     = 4'd5;
    localparam logic [3:0] S_T     = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]            st_reg;
    logic [3:0]            step_reg;
    logic signed [VB-1:0]  e1_reg [3];
    logic signed [VB-1:0]  e2_reg [3];
    logic signed [VB-1:0]  d_reg [3];
    logic signed [VB-1:0]  tv_reg [3];
    logic signed [CB-1:0]  pv_reg [3];
    logic signed [CB-1:0]  qv_reg [3];
    logic signed [SB-1:0]  acc_reg;
    logic signed [SB-1:0]  det_reg;
    logic signed [SB-1:0]  u_reg;
    logic signed [SB-1:0]  v_reg;
    logic signed [SB-1:0]  tn_reg;
    logic [1:0]            dsel_reg;
    logic [CW-1:0]         bit_reg;
    logic [NB-1:0]         num_reg;
    logic [SB:0]           rem_reg;
    logic [QW-1:0]         quo_reg;
    logic                  ovf_reg;
    logic [QW-1:0]         uq_reg;
    logic [QW-1:0]         vq_reg;
    logic [2:0]            calc_st_reg;
    logic [31:0]           calc_t_reg;
    logic [16:0]           calc_u_reg;
    logic [16:0]           calc_v_w_reg;
    logic                  out_v_reg;
    logic [2:0]            out_st_reg;
    logic [31:0]           out_t_reg;
    logic [16:0]           out_u_reg;
    logic [16:0]           out_v_w_reg;

    logic signed [CB-1:0]  ma;
    logic signed [VB-1:0]  mb;
    logic signed [SB-1:0]  prod;
    logic [SB:0]           rem_sh;
    logic [SB:0]           rem_sub;
    logic [SB-1:0]         det_u;
    logic                  busy_out;

    // Sign-fixed operand multiplexer: one multiply per cycle.
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (st_reg)
            S_PX:
            begin
                // pv = d x e2, each component as two products: step 0..5
                case (step_reg)
                    4'd0: begin ma = CB'(d_reg[1]);  mb = e2_reg[2]; end
                    4'd1: begin ma = CB'(d_reg[2]);  mb = -e2_reg[1]; end
                    4'd2: begin ma = CB'(d_reg[2]);  mb = e2_reg[0]; end
                    4'd3: begin ma = CB'(d_reg[0]);  mb = -e2_reg[2]; end
                    4'd4: begin ma = CB'(d_reg[0]);  mb = e2_reg[1]; end
                    default: begin ma = CB'(d_reg[1]); mb = -e2_reg[0]; end
                endcase
            end
            S_QX:
            begin
                case (step_reg)
                    4'd0: begin ma = CB'(tv_reg[1]); mb = e1_reg[2]; end
                    4'd1: begin ma = CB'(tv_reg[2]); mb = -e1_reg[1]; end
                    4'd2: begin ma = CB'(tv_reg[2]); mb = e1_reg[0]; end
                    4'd3: begin ma = CB'(tv_reg[0]); mb = -e1_reg[2]; end
                    4'd4: begin ma = CB'(tv_reg[0]); mb = e1_reg[1]; end
                    default: begin ma = CB'(tv_reg[1]); mb = -e1_reg[0]; end
                endcase
            end
            S_DET:
            begin
                ma = pv_reg[step_reg[1:0]];
                mb = e1_reg[step_reg[1:0]];
            end
            S_U:
            begin
                ma = pv_reg[step_reg[1:0]];
                mb = tv_reg[step_reg[1:0]];
            end
            S_V:
            begin
                ma = qv_reg[step_reg[1:0]];
                mb = d_reg[step_reg[1:0]];
            end
            S_T:
            begin
                ma = qv_reg[step_reg[1:0]];
                mb = e2_reg[step_reg[1:0]];
            end
            default:
            begin
            end
        endcase
        prod = SB'(ma) * SB'(mb);
    end

    assign det_u    = unsigned'(det_reg);
    assign rem_sh   = {rem_reg[SB-1:0], num_reg[NB-1]};
    assign rem_sub  = rem_sh - {1'b0, det_u};
    assign busy_out = out_v_reg && !res_ready;
    assign cmd_ready = (st_reg == S_IDLE);

    assign res_valid = out_v_reg;
    assign status    = out_st_reg;
    assign hit       = (out_st_reg == rti_pkg::ST_HIT);
    assign t_value   = out_t_reg;
    assign u_weight  = out_u_reg;
    assign v_weight  = out_v_w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IDLE;
            step_reg  <= '0;
            out_v_reg <= 1'b0;
            dsel_reg  <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            if (out_v_reg && res_ready && (st_reg != S_OUT))
            begin
                out_v_reg <= 1'b0;
            end
            case (st_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            e1_reg[k] <= cmd_data[k*VB +: VB];
                            e2_reg[k] <= cmd_data[(3+k)*VB +: VB];
                            tv_reg[k] <= cmd_data[(6+k)*VB +: VB];
                            d_reg[k]  <= cmd_data[(9+k)*VB +: VB];
                        end
                        st_reg   <= S_PX;
                        step_reg <= '0;
                    end
                end
                S_PX, S_QX:
                begin
                    if (step_reg[0] == 1'b0)
                    begin
                        acc_reg <= prod;
                    end
                    else if (st_reg == S_PX)
                    begin
                        pv_reg[step_reg[2:1]] <= CB'(acc_reg + prod);
                    end
                    else
                    begin
                        qv_reg[step_reg[2:1]] <= CB'(acc_reg + prod);
                    end
                    if (step_reg == 4'd5)
                    begin
                        step_reg <= '0;
                        acc_reg  <= '0;
                        st_reg   <= (st_reg == S_PX) ? S_DET : S_V;
                    end
                    else
                    begin
                        step_reg <= step_reg + 4'd1;
                    end
                end
                S_DET, S_U, S_V, S_T:
                begin
                    if (step_reg == 4'd3)
                    begin
                        step_reg <= '0;
                        acc_reg  <= '0;
                        case (st_reg)
                            S_DET:
                            begin
                                if (acc_reg <= 0)
                                begin
                                    det_reg <= -acc_reg;
                                    for (int k = 0; k < 3; k++) tv_reg[k] <= -tv_reg[k];
                                    if (acc_reg == 0 ||
                                        (-acc_reg) < $signed({1'b0, SB'(det_threshold)}))
                                    begin
                                        st_reg <= S_OUT;
                                        calc_st_reg <= rti_pkg::ST_PARALLEL;
                                    end
                                    else
                                    begin
                                        st_reg <= S_U;
                                    end
                                end
                                else
                                begin
                                    det_reg <= acc_reg;
                                    if (acc_reg < $signed({1'b0, SB'(det_threshold)}))
                                    begin
                                        st_reg <= S_OUT;
                                        calc_st_reg <= rti_pkg::ST_PARALLEL;
                                    end
                                    else
                                    begin
                                        st_reg <= S_U;
                                    end
                                end
                            end
                            S_U:
                            begin
                                u_reg <= acc_reg;
                                if (acc_reg < 0 || det_reg < acc_reg)
                                begin
                                    st_reg <= S_OUT;
                                    calc_st_reg <= rti_pkg::ST_U_OUT;
                                end
                                else
                                begin
                                    st_reg <= S_QX;
                                end
                            end
                            S_V:
                            begin
                                v_reg <= acc_reg;
                                if (acc_reg < 0 || det_reg < (u_reg + acc_reg))
                                begin
                                    st_reg <= S_OUT;
                                    calc_st_reg <= rti_pkg::ST_V_OUT;
                                end
                                else
                                begin
                                    st_reg <= S_T;
                                end
                            end
                            default:
                            begin
                                tn_reg   <= acc_reg;
                                st_reg   <= S_DIV;
                                dsel_reg <= 2'd0;
                                bit_reg  <= CW'(NB);
                                rem_reg  <= '0;
                                quo_reg  <= '0;
                                ovf_reg  <= 1'b0;
                                num_reg  <= {unsigned'(u_reg), 16'd0};
                            end
                        endcase
                    end
                    else
                    begin
                        acc_reg  <= acc_reg + prod;
                        step_reg <= step_reg + 4'd1;
                    end
                end
                S_DIV:
                begin
                    if (bit_reg != '0)
                    begin
                        num_reg <= num_reg << 1;
                        ovf_reg <= ovf_reg || quo_reg[QW-1];
                        if (!rem_sub[SB])
                        begin
                            rem_reg <= rem_sub;
                            quo_reg <= {quo_reg[QW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[QW-2:0], 1'b0};
                        end
                        bit_reg <= bit_reg - CW'(1);
                    end
                    else
                    begin
                        bit_reg <= CW'(NB);
                        rem_reg <= '0;
                        quo_reg <= '0;
                        ovf_reg <= 1'b0;
                        case (dsel_reg)
                            2'd0:
                            begin
                                uq_reg   <= quo_reg;
                                num_reg  <= {unsigned'(v_reg), 16'd0};
                                dsel_reg <= 2'd1;
                            end
                            2'd1:
                            begin
                                vq_reg   <= quo_reg;
                                num_reg  <= {unsigned'(tn_reg < 0 ? -tn_reg : tn_reg), 16'd0};
                                dsel_reg <= 2'd2;
                            end
                            default:
                            begin
                                st_reg <= S_OUT;
                                calc_st_reg <= (tn_reg > 0) ? rti_pkg::ST_HIT
                                                            : rti_pkg::ST_BEHIND;
                                if (tn_reg >= 0)
                                begin
                                    calc_t_reg <= (ovf_reg ||
                                                   quo_reg > QW'(rti_pkg::T_MAX)) ?
                                                  rti_pkg::T_MAX : quo_reg[31:0];
                                end
                                else
                                begin
                                    calc_t_reg <= (ovf_reg ||
                                                   quo_reg > QW'(rti_pkg::T_MIN)) ?
                                                  rti_pkg::T_MIN : 32'(-quo_reg);
                                end
                                calc_u_reg   <= uq_reg[16:0];
                                calc_v_w_reg <= vq_reg[16:0];
                            end
                        endcase
                    end
                end
                S_OUT:
                begin
                    if (!busy_out)
                    begin
                        out_v_reg  <= 1'b1;
                        out_st_reg <= calc_st_reg;
                        st_reg     <= S_IDLE;
                        if (calc_st_reg == rti_pkg::ST_PARALLEL ||
                            calc_st_reg == rti_pkg::ST_U_OUT ||
                            calc_st_reg == rti_pkg::ST_V_OUT)
                        begin
                            out_t_reg   <= rti_pkg::T_REJECT;
                            out_u_reg   <= '0;
                            out_v_w_reg <= '0;
                        end
                        else
                        begin
                            out_t_reg   <= calc_t_reg;
                            out_u_reg   <= calc_u_reg;
                            out_v_w_reg <= calc_v_w_reg;
                        end
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && hit |-> t_value[31] == 1'b0)
        else $error("hit with negative distance");
    a_reject_t: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == rti_pkg::ST_PARALLEL) |-> t_value == rti_pkg::T_REJECT)
        else $error("rejected result without t of -1");
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> st_reg == S_IDLE)
        else $error("command taken while busy");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(t_value))
        else $error("result dropped while stalled");

endmodule

[src/ray_triangle_intersect.sv]
// Top level of the two-sided ray/triangle intersection block; uses rti_pkg and its parts.
// A test that reaches the divider runs its products on one shared multiplier, then
// three restoring divisions (u, v, t) and the output state. Rejected tests finish earlier.
// Loads are always accepted; tests run one at a time through the back part.
// Reset (rst_n, async, active low) clears stores and queue and restores the threshold.
module ray_triangle_intersect #(
    parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [2:0]                   s_tuser,  // mode
    input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_tdata, // coord_x, coord_y, coord_z
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [3:0]                   m_tuser,  // status, hit
    output logic [71:0]                  m_tdata,  // t_value, u_weight, v_weight
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rti_pkg::THR_BITS-1:0] cfg_data
);

    localparam int VB = COORD_BITS + 1;
    localparam int FW = 12 * VB;

    logic [rti_pkg::THR_BITS-1:0] thr_reg;
    logic        f_valid;
    logic        f_ready;
    logic [9*VB-1:0] f_data;
    logic [FW-1:0]   q_in;
    logic        q_valid;
    logic        q_ready;
    logic [FW-1:0] q_data;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] cz;
    logic [2:0]  status;
    logic        hit;
    logic [31:0] t_value;
    logic [16:0] u_weight;
    logic [16:0] v_weight;

    assign cx = s_tdata[COORD_BITS-1:0];
    assign cy = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign cz = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign q_in = {VB'(cz), VB'(cy), VB'(cx), f_data};
    assign cfg_ready = 1'b1;
    assign m_tuser = {hit, status};
    assign m_tdata = {6'd0, v_weight, u_weight, t_value};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= rti_pkg::THR_RESET;
        end
        else if (cfg_valid)
        begin
            thr_reg <= cfg_data;
        end
    end

    rti_front #(.COORD_BITS(COORD_BITS), .VB(VB)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready), .mode(s_tuser),
        .cx(cx), .cy(cy), .cz(cz),
        .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd_data(f_data)
    );

    rti_fifo #(.W(FW)) u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(q_in),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
    );

    rti_back #(.COORD_BITS(COORD_BITS), .VB(VB)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd_data(q_data),
        .det_threshold(thr_reg),
        .res_valid(m_tvalid), .res_ready(m_tready),
        .status(status), .hit(hit), .t_value(t_value),
        .u_weight(u_weight), .v_weight(v_weight)
    );

endmodule
